// File: src/bcdc_pkg.sv
`default_nettype none
package bcdc_pkg;

   localparam int NumDigits = 6;
   localparam int DigitW = 4;
   localparam int PosW = 3;
   localparam int GlyphW = 15;
   localparam int NumGlyphs = 10;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_SET  = 1'b1
   } kind_type;

   typedef struct packed {
      logic [NumDigits-1:0]             emit;
      logic [NumDigits-1:0][DigitW-1:0] value;
   } update_type;

   function automatic logic [GlyphW-1:0] glyph(input logic [DigitW-1:0] v);
      logic [GlyphW-1:0] g;
      case (v)
         4'd0:    g = 15'h7B6F;
         4'd1:    g = 15'h1249;
         4'd2:    g = 15'h73E7;
         4'd3:    g = 15'h73CF;
         4'd4:    g = 15'h5BC9;
         4'd5:    g = 15'h79CF;
         4'd6:    g = 15'h79EF;
         4'd7:    g = 15'h7249;
         4'd8:    g = 15'h7BEF;
         4'd9:    g = 15'h7BCF;
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

// File: src/bcdc_time.sv
`default_nettype none
module bcdc_time (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               kind,
   input  wire logic [4:0]         set_hours,
   input  wire logic [5:0]         set_minutes,
   input  wire logic [5:0]         set_seconds,
   output bcdc_pkg::update_type    update
);
   import bcdc_pkg::*;

   logic [3:0] sec_ones_ff, sec_ones_in;
   logic [2:0] sec_tens_ff, sec_tens_in;
   logic [3:0] min_ones_ff, min_ones_in;
   logic [2:0] min_tens_ff, min_tens_in;
   logic [3:0] hr_ones_ff, hr_ones_in;
   logic [1:0] hr_tens_ff, hr_tens_in;

   logic [NumDigits-1:0][DigitW-1:0] cur;
   logic [NumDigits-1:0][DigitW-1:0] nxt;
   logic [4:0] hours_c;
   logic [5:0] minutes_c;
   logic [5:0] seconds_c;

   function automatic logic [6:0] split_bcd(input logic [5:0] v);
      logic [2:0] t;
      logic [5:0] r;
      t = 3'd0;
      if (v >= 6'd10) t = 3'd1;
      if (v >= 6'd20) t = 3'd2;
      if (v >= 6'd30) t = 3'd3;
      if (v >= 6'd40) t = 3'd4;
      if (v >= 6'd50) t = 3'd5;
      r = v - 6'({3'd0, t} * 6'd10);
      return {t, r[3:0]};
   endfunction

   always_comb begin
      cur[0] = sec_ones_ff;
      cur[1] = {1'b0, sec_tens_ff};
      cur[2] = min_ones_ff;
      cur[3] = {1'b0, min_tens_ff};
      cur[4] = hr_ones_ff;
      cur[5] = {2'b0, hr_tens_ff};

      hours_c   = (set_hours > 5'd23) ? 5'd23 : set_hours;
      minutes_c = (set_minutes > 6'd59) ? 6'd59 : set_minutes;
      seconds_c = (set_seconds > 6'd59) ? 6'd59 : set_seconds;

      nxt = cur;
      if (kind == KIND_SET) begin
         {nxt[1][2:0], nxt[0]} = split_bcd(seconds_c);
         nxt[1][3] = 1'b0;
         {nxt[3][2:0], nxt[2]} = split_bcd(minutes_c);
         nxt[3][3] = 1'b0;
         {nxt[5][2:0], nxt[4]} = split_bcd({1'b0, hours_c});
         nxt[5][3] = 1'b0;
         update.emit = '1;
      end else begin
         nxt[0] = cur[0] + 4'd1;
         if (nxt[0] >= 4'd10) begin
            nxt[0] = 4'd0;
            nxt[1] = cur[1] + 4'd1;
            if (nxt[1] >= 4'd6) begin
               nxt[1] = 4'd0;
               nxt[2] = cur[2] + 4'd1;
               if (nxt[2] >= 4'd10) begin
                  nxt[2] = 4'd0;
                  nxt[3] = cur[3] + 4'd1;
                  if (nxt[3] >= 4'd6) begin
                     nxt[3] = 4'd0;
                     nxt[4] = cur[4] + 4'd1;
                     if (cur[5] >= 4'd2 && nxt[4] >= 4'd4) begin
                        nxt[4] = 4'd0;
                        nxt[5] = 4'd0;
                     end else if (nxt[4] >= 4'd10) begin
                        nxt[4] = 4'd0;
                        nxt[5] = cur[5] + 4'd1;
                     end
                  end
               end
            end
         end
         for (int i = 0; i < NumDigits; i++) begin
            update.emit[i] = (nxt[i] != cur[i]);
         end
      end
      update.value = nxt;

      sec_ones_in = sec_ones_ff;
      sec_tens_in = sec_tens_ff;
      min_ones_in = min_ones_ff;
      min_tens_in = min_tens_ff;
      hr_ones_in  = hr_ones_ff;
      hr_tens_in  = hr_tens_ff;
      if (accept) begin
         sec_ones_in = nxt[0];
         sec_tens_in = nxt[1][2:0];
         min_ones_in = nxt[2];
         min_tens_in = nxt[3][2:0];
         hr_ones_in  = nxt[4];
         hr_tens_in  = nxt[5][1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ones_ff <= '0;
         sec_tens_ff <= '0;
         min_ones_ff <= '0;
         min_tens_ff <= '0;
         hr_ones_ff  <= '0;
         hr_tens_ff  <= '0;
      end else begin
         sec_ones_ff <= sec_ones_in;
         sec_tens_ff <= sec_tens_in;
         min_ones_ff <= min_ones_in;
         min_tens_ff <= min_tens_in;
         hr_ones_ff  <= hr_ones_in;
         hr_tens_ff  <= hr_tens_in;
      end
   end

endmodule
`default_nettype wire

// File: src/bcdc_seq.sv
`default_nettype none
module bcdc_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire bcdc_pkg::update_type          update,
   output logic                               ready,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [bcdc_pkg::PosW-1:0]          out_position,
   output logic [bcdc_pkg::DigitW-1:0]        out_value,
   output logic [bcdc_pkg::GlyphW-1:0]        out_glyph,
   output logic                               out_last
);
   import bcdc_pkg::*;

   logic [NumDigits-1:0]             pend_mask_ff, pend_mask_in;
   logic [NumDigits-1:0][DigitW-1:0] pend_val_ff, pend_val_in;
   logic                             out_valid_ff, out_valid_in;
   logic [PosW-1:0]                  out_pos_ff, out_pos_in;
   logic [DigitW-1:0]                out_val_ff, out_val_in;
   logic [GlyphW-1:0]                out_glyph_ff, out_glyph_in;
   logic                             out_last_ff, out_last_in;

   logic                 out_load;
   logic [NumDigits-1:0] pick;
   logic [PosW-1:0]      pick_pos;
   logic [NumDigits-1:0] mask_left;
   logic [NumDigits-1:0] mask_after;

   always_comb begin
      pick = '0;
      pick_pos = '0;
      for (int i = NumDigits - 1; i >= 0; i--) begin
         if (pend_mask_ff[i]) begin
            pick = '0;
            pick[i] = 1'b1;
            pick_pos = PosW'(i);
         end
      end
      mask_left = pend_mask_ff & ~pick;
      out_load = !out_valid_ff || out_ready;
      mask_after = out_load ? mask_left : pend_mask_ff;
      ready = (mask_after == '0);

      pend_mask_in = mask_after;
      pend_val_in = pend_val_ff;
      if (accept) begin
         pend_mask_in = update.emit;
         pend_val_in = update.value;
      end

      out_valid_in = out_valid_ff;
      out_pos_in = out_pos_ff;
      out_val_in = out_val_ff;
      out_glyph_in = out_glyph_ff;
      out_last_in = out_last_ff;
      if (out_load) begin
         out_valid_in = |pend_mask_ff;
         out_pos_in = pick_pos;
         out_val_in = pend_val_ff[pick_pos];
         out_glyph_in = glyph(pend_val_ff[pick_pos]);
         out_last_in = (mask_left == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_mask_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_mask_ff <= pend_mask_in;
         out_valid_ff <= out_valid_in;
      end
      pend_val_ff <= pend_val_in;
      out_pos_ff <= out_pos_in;
      out_val_ff <= out_val_in;
      out_glyph_ff <= out_glyph_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_position = out_pos_ff;
   assign out_value = out_val_ff;
   assign out_glyph = out_glyph_ff;
   assign out_last = out_last_ff;

`ifndef SYNTHESIS
   // Every request changes at least the seconds ones digit.
   a_pend_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_mask_ff[0])
      else $error("request left no pending seconds digit");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_val_ff <= DigitW'(9))
      else $error("digit value out of range");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_pos_ff <= PosW'(NumDigits - 1))
      else $error("digit position out of range");

   a_glyph_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_glyph_ff != '0)
      else $error("empty glyph on a valid result");
`endif

endmodule
`default_nettype wire

// File: src/bcd_clock_with_digit_glyphs.sv
`default_nettype none
// A 24-hour HH:MM:SS clock kept as six BCD digits. A request with tuser set
// loads the time from tdata, clamping hours to 23 and minutes and seconds to
// 59, and returns all six digits; a request with tuser clear adds one second
// and returns only the digits that changed, seconds ones first. Each result
// carries the digit position, its value and its 3x5 glyph, and tlast marks
// the final result of a request. The result port delivers one digit per
// cycle while rsp_tready stays high, so a request yields one to six results
// (a set always six), and a new request is taken in the cycle that the previous
// one's last digit moves into the output register. The digits of an accepted
// request wait in a pending register and move into the output register in turn.
module bcd_clock_with_digit_glyphs (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [4:0] set_hours, [10:5] set_minutes, [16:11] set_seconds, [23:17] zero
   input  wire logic [23:0] req_tdata,
   // [0] kind
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] digit_position, [6:3] digit_value, [21:7] glyph_mask, [23:22] zero
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast
);
   import bcdc_pkg::*;

   logic                accept;
   update_type          update;
   logic [PosW-1:0]     position;
   logic [DigitW-1:0]   value;
   logic [GlyphW-1:0]   glyph_bits;

   assign accept = req_tvalid && req_tready;

   bcdc_time u_time (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_tuser[0]),
      .set_hours   (req_tdata[4:0]),
      .set_minutes (req_tdata[10:5]),
      .set_seconds (req_tdata[16:11]),
      .update      (update)
   );

   bcdc_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .update       (update),
      .ready        (req_tready),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_position (position),
      .out_value    (value),
      .out_glyph    (glyph_bits),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, glyph_bits, value, position};

endmodule
`default_nettype wire
